>>> rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the ping-pong stereo delay: register
// indexes, Q0.16 gain limits and the command and status groups between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIX      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWPASS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS   = 3'd4;

  // Q0.16 gain limits and rounding offset
  localparam logic [15:0] FB_CAP     = 16'd64225;
  localparam logic [16:0] UNITY      = 17'd65536;
  localparam int          ROUND_HALF = 32768;
  localparam int          Q_SHIFT    = 16;

  // Gain settings after clamping
  typedef struct packed {
    logic [15:0] feedback;
    logic [16:0] mix;
    logic [16:0] coeff;
    logic        bypass;
  } psd_gain_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load;      // capture input pair, issue line read
    logic filter;    // lowpass and mix products
    logic feedback;  // update lowpass, feedback product, output value
    logic commit;    // write lines, advance index, hand over result
    logic pass;      // hand over the input pair unchanged
  } psd_cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic out_free;
    logic bypass;
  } psd_stat_t;

endpackage

>>> rtl/core/psd_if.sv
// ----------------------------------------------------------------------------
// psd_if
// Channel interfaces of the ping-pong stereo delay: input pair, output pair
// and configuration write.
// ----------------------------------------------------------------------------
interface psd_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface psd_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

interface psd_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [psd_pkg::CFG_INDEX_W-1:0]  index;
  logic [psd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/psd_cfg.sv
// ----------------------------------------------------------------------------
// psd_cfg
// Configuration registers. Values are clamped to their legal range when
// written, so the datapath sees usable settings only.
// ----------------------------------------------------------------------------
module psd_cfg #(
  parameter int LINE_DEPTH = 32768
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_valid,
  output logic                               wr_ready,
  input  logic [psd_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]     wr_data,
  output logic [$clog2(LINE_DEPTH)-1:0]      delay,
  output psd_pkg::psd_gain_t                 gain
);
  import psd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  logic [AW-1:0] delay_next;
  logic [14:0]   delay_raw;

  assign wr_ready  = 1'b1;
  assign delay_raw = wr_data[14:0];

  // Clamp delay into 1 .. LINE_DEPTH-1
  always_comb begin
    priority if (delay_raw == 15'd0) begin
      delay_next = AW'(1);
    end else if (32'(delay_raw) > 32'(LINE_DEPTH - 1)) begin
      delay_next = AW'(LINE_DEPTH - 1);
    end else begin
      delay_next = AW'(delay_raw);
    end
  end

  // Hold register values, update on write
  always_ff @(posedge clk) begin
    if (rst) begin
      delay       <= AW'(1);
      gain.feedback <= '0;
      gain.mix    <= '0;
      gain.coeff  <= UNITY;
      gain.bypass <= 1'b0;
    end else if (wr_valid) begin
      unique case (wr_index)
        CFG_DELAY: begin
          delay <= delay_next;
        end
        CFG_FEEDBACK: begin
          gain.feedback <= (wr_data[15:0] > FB_CAP) ? FB_CAP : wr_data[15:0];
        end
        CFG_MIX: begin
          gain.mix <= (wr_data > UNITY) ? UNITY : wr_data;
        end
        CFG_LOWPASS: begin
          gain.coeff <= (wr_data > UNITY) ? UNITY : wr_data;
        end
        CFG_BYPASS: begin
          gain.bypass <= wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: steps one item through read, filter, feedback and commit, or
// straight to hand-over in bypass.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psd_pkg::psd_stat_t stat,
  output psd_pkg::psd_cmd_t  cmd
);
  import psd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILTER,
    S_FEEDBACK,
    S_COMMIT,
    S_PASS
  } state_t;

  state_t state;

  // Decode commands from state
  assign in_ready     = (state == S_IDLE);
  assign cmd.load     = in_valid && in_ready;
  assign cmd.filter   = (state == S_FILTER);
  assign cmd.feedback = (state == S_FEEDBACK);
  assign cmd.commit   = (state == S_COMMIT) && stat.out_free;
  assign cmd.pass     = (state == S_PASS) && stat.out_free;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.bypass ? S_PASS : S_FILTER;
          end
        end
        S_FILTER: begin
          state <= S_FEEDBACK;
        end
        S_FEEDBACK: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_PASS: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.filter, cmd.feedback, cmd.commit, cmd.pass}))
    else $error("more than one datapath command at once");

  a_load_path: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !stat.bypass |=> cmd.filter ##1 cmd.feedback)
    else $error("processed item skipped a step");

  a_load_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.load && stat.bypass |=> state == S_PASS)
    else $error("bypassed item did not go to hand-over");

endmodule

>>> rtl/core/psd_datapath.sv
// ----------------------------------------------------------------------------
// psd_datapath
// Delay lines, write index, lowpass states, Q0.16 multipliers and the
// output register.
// ----------------------------------------------------------------------------
module psd_datapath #(
  parameter int LINE_DEPTH  = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psd_pkg::psd_cmd_t             cmd,
  output psd_pkg::psd_stat_t            stat,
  input  logic [$clog2(LINE_DEPTH)-1:0] delay,
  input  psd_pkg::psd_gain_t            gain,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right
);
  import psd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 19;  // (difference) x (Q0.16 gain up to 1.0)
  localparam int FW = SB + 17;  // (sample) x (feedback gain)

  // Delay lines
  logic signed [SB-1:0] left_line  [LINE_DEPTH];
  logic signed [SB-1:0] right_line [LINE_DEPTH];

  logic [AW-1:0]        wr_index;
  logic                 wrapped;
  logic [AW:0]          rd_diff;
  logic [AW:0]          rd_wrap;
  logic [AW-1:0]        rd_addr;
  logic                 rd_valid;
  logic signed [SB-1:0] rdata_left;   // from left line
  logic signed [SB-1:0] rdata_right;  // from right line

  logic signed [SB-1:0] x_left;
  logic signed [SB-1:0] x_right;
  logic signed [SB-1:0] lp_left;
  logic signed [SB-1:0] lp_right;

  // Filter step
  logic signed [SB-1:0] d_left;
  logic signed [SB-1:0] d_right;
  logic signed [SB:0]   lp_diff_left;
  logic signed [SB:0]   lp_diff_right;
  logic signed [SB:0]   mix_diff_left;
  logic signed [SB:0]   mix_diff_right;
  logic signed [17:0]   coeff_s;
  logic signed [17:0]   mix_s;
  logic signed [PW-1:0] prod_lp_left;
  logic signed [PW-1:0] prod_lp_right;
  logic signed [PW-1:0] prod_mix_left;
  logic signed [PW-1:0] prod_mix_right;

  // Feedback step
  logic signed [PW-1:0] rnd_lp_left;
  logic signed [PW-1:0] rnd_lp_right;
  logic signed [PW-1:0] rnd_mix_left;
  logic signed [PW-1:0] rnd_mix_right;
  logic signed [SB+1:0] lp_sum_left;
  logic signed [SB+1:0] lp_sum_right;
  logic signed [SB-1:0] lp_new_left;
  logic signed [SB-1:0] lp_new_right;
  logic signed [SB+1:0] mix_sum_left;
  logic signed [SB+1:0] mix_sum_right;
  logic signed [16:0]   fb_s;
  logic signed [FW-1:0] prod_fb_left;
  logic signed [FW-1:0] prod_fb_right;
  logic signed [SB-1:0] wet_left;
  logic signed [SB-1:0] wet_right;

  // Commit step
  logic signed [FW-1:0] rnd_fb_left;
  logic signed [FW-1:0] rnd_fb_right;
  logic signed [SB+1:0] wr_sum_left;
  logic signed [SB+1:0] wr_sum_right;

  // Clip a widened sample to the signed sample range
  function automatic logic signed [SB-1:0] sat(input logic signed [SB+1:0] v);
    logic signed [SB-1:0] r;
    if ((v[SB+1:SB-1] == 3'b000) || (v[SB+1:SB-1] == 3'b111)) begin
      r = v[SB-1:0];
    end else if (v[SB+1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  assign stat.out_free = !out_valid || out_ready;
  assign stat.bypass   = gain.bypass;

  // Read position: write index minus delay, modulo the line depth
  assign rd_diff = {1'b0, wr_index} - {1'b0, delay};
  assign rd_wrap = rd_diff + (AW+1)'(LINE_DEPTH);
  assign rd_addr = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];

  // Left line: read on load, write on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata_left <= left_line[rd_addr];
    end
    if (cmd.commit) begin
      left_line[wr_index] <= sat(wr_sum_left);
    end
  end

  // Right line: read on load, write on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata_right <= right_line[rd_addr];
    end
    if (cmd.commit) begin
      right_line[wr_index] <= sat(wr_sum_right);
    end
  end

  // Capture input pair; entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_left   <= in_left;
      x_right  <= in_right;
      rd_valid <= wrapped || !rd_diff[AW];
    end
  end

  // Cross the lines: left path reads the right line
  assign d_left  = rd_valid ? rdata_right : '0;
  assign d_right = rd_valid ? rdata_left  : '0;

  assign lp_diff_left   = (SB+1)'(d_left)  - (SB+1)'(lp_left);
  assign lp_diff_right  = (SB+1)'(d_right) - (SB+1)'(lp_right);
  assign mix_diff_left  = (SB+1)'(d_left)  - (SB+1)'(x_left);
  assign mix_diff_right = (SB+1)'(d_right) - (SB+1)'(x_right);
  assign coeff_s        = {1'b0, gain.coeff};
  assign mix_s          = {1'b0, gain.mix};

  // Multiply lowpass and mix differences
  always_ff @(posedge clk) begin
    if (cmd.filter) begin
      prod_lp_left   <= PW'(lp_diff_left)   * PW'(coeff_s);
      prod_lp_right  <= PW'(lp_diff_right)  * PW'(coeff_s);
      prod_mix_left  <= PW'(mix_diff_left)  * PW'(mix_s);
      prod_mix_right <= PW'(mix_diff_right) * PW'(mix_s);
    end
  end

  // Round to nearest, ties upward
  assign rnd_lp_left   = (prod_lp_left   + PW'(ROUND_HALF)) >>> Q_SHIFT;
  assign rnd_lp_right  = (prod_lp_right  + PW'(ROUND_HALF)) >>> Q_SHIFT;
  assign rnd_mix_left  = (prod_mix_left  + PW'(ROUND_HALF)) >>> Q_SHIFT;
  assign rnd_mix_right = (prod_mix_right + PW'(ROUND_HALF)) >>> Q_SHIFT;

  assign lp_sum_left   = (SB+2)'(lp_left)  + rnd_lp_left[SB+1:0];
  assign lp_sum_right  = (SB+2)'(lp_right) + rnd_lp_right[SB+1:0];
  assign lp_new_left   = lp_sum_left[SB-1:0];
  assign lp_new_right  = lp_sum_right[SB-1:0];
  assign mix_sum_left  = (SB+2)'(x_left)  + rnd_mix_left[SB+1:0];
  assign mix_sum_right = (SB+2)'(x_right) + rnd_mix_right[SB+1:0];
  assign fb_s          = {1'b0, gain.feedback};

  // Update lowpass states, form feedback products and the wet result
  always_ff @(posedge clk) begin
    if (rst) begin
      lp_left  <= '0;
      lp_right <= '0;
    end else if (cmd.feedback) begin
      lp_left  <= lp_new_left;
      lp_right <= lp_new_right;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feedback) begin
      prod_fb_left  <= FW'(lp_new_left)  * FW'(fb_s);
      prod_fb_right <= FW'(lp_new_right) * FW'(fb_s);
      wet_left      <= sat(mix_sum_left);
      wet_right     <= sat(mix_sum_right);
    end
  end

  assign rnd_fb_left  = (prod_fb_left  + FW'(ROUND_HALF)) >>> Q_SHIFT;
  assign rnd_fb_right = (prod_fb_right + FW'(ROUND_HALF)) >>> Q_SHIFT;
  assign wr_sum_left  = (SB+2)'(x_left)  + rnd_fb_left[SB+1:0];
  assign wr_sum_right = (SB+2)'(x_right) + rnd_fb_right[SB+1:0];

  // Advance write index; note the first wrap, after which all entries hold data
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_index <= '0;
      wrapped  <= 1'b0;
    end else if (cmd.commit) begin
      if (wr_index == AW'(LINE_DEPTH - 1)) begin
        wr_index <= '0;
        wrapped  <= 1'b1;
      end else begin
        wr_index <= wr_index + AW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit || cmd.pass) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_left  <= wet_left;
      out_right <= wet_right;
    end else if (cmd.pass) begin
      out_left  <= x_left;
      out_right <= x_right;
    end
  end

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.commit || cmd.pass |=> out_valid)
    else $error("result not presented after hand-over");

  a_index_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(wr_index) && $stable(lp_left) || $past(cmd.feedback))
    else $error("state changed outside an item's steps");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !cmd.commit && !cmd.pass)
    else $error("waiting result overwritten");

endmodule

>>> rtl/core/pingpong_stereo_delay.sv
// ----------------------------------------------------------------------------
// pingpong_stereo_delay
// Ping-pong stereo delay with a one-pole lowpass in the feedback path,
// signed Q3.20 samples and Q0.16 gains.
// ----------------------------------------------------------------------------
//  channel    dir   handshake      payload
//  audio_in   in    valid/ready    in_left, in_right
//  audio_out  out   valid/ready    out_left, out_right
//  cfg        in    valid/ready    index, data (ready always high)
//
//  An item steps through accept with line read, filter multiply, feedback
//  multiply and commit with line write; the single read/write port of each
//  delay line and the dependent multiplies set this. Bypass skips to hand-over.
//  A result waiting in the output register stalls commit (or bypass hand-over)
//  of the next item only; the next item is accepted meanwhile.
//  Reset clears control, index and lowpass state at once; lines need no
//  clearing pass, entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module pingpong_stereo_delay #(
  parameter int LINE_DEPTH  = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic     clk,
  input  logic     rst,
  psd_in_if.sink   audio_in,
  psd_out_if.source audio_out,
  psd_cfg_if.sink  cfg
);
  import psd_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);

  logic [AW-1:0] delay;
  psd_gain_t     gain;
  psd_cmd_t      cmd;
  psd_stat_t     stat;

  psd_cfg #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .delay    (delay),
    .gain     (gain)
  );

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (audio_in.valid),
    .in_ready (audio_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psd_datapath #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .delay     (delay),
    .gain      (gain),
    .in_left   (audio_in.in_left),
    .in_right  (audio_in.in_right),
    .out_valid (audio_out.valid),
    .out_ready (audio_out.ready),
    .out_left  (audio_out.out_left),
    .out_right (audio_out.out_right)
  );

endmodule

>>> verif/tb_pingpong_stereo_delay.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pingpong_stereo_delay
// Self-checking bench for the ping-pong stereo delay. A bit-accurate model
// of the delay lines, lowpass states and wet/dry mix predicts every output
// pair; a scoreboard compares the pairs in order. Stimulus runs a directed
// set of extremes and register corner cases, then random register settings
// with random sample pairs, bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_pingpong_stereo_delay;
  import psd_pkg::*;

  localparam int LINE_DEPTH  = 32768;
  localparam int SAMPLE_BITS = 24;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT  = 4000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_pair_t;

  // Delay-line predictor plus in-order comparison of output pairs
  class stereo_delay_scoreboard;
    sample_t      left_line[LINE_DEPTH];
    sample_t      right_line[LINE_DEPTH];
    logic [14:0]  write_index;
    longint       left_lowpass;
    longint       right_lowpass;
    logic [14:0]  delay_reg;
    logic [15:0]  feedback_reg;
    logic [16:0]  mix_reg;
    logic [16:0]  coeff_reg;
    logic         bypass_reg;
    stereo_pair_t expected_pairs[$];
    int           errors;

    function new();
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      write_index   = '0;
      left_lowpass  = 0;
      right_lowpass = 0;
      delay_reg     = 15'd1;
      feedback_reg  = '0;
      mix_reg       = '0;
      coeff_reg     = UNITY;
      bypass_reg    = 1'b0;
      errors        = 0;
    endfunction

    // Q0.16 product, rounded to nearest with ties toward +inf
    static function longint scale_q16(longint x, longint g);
      return (x * g + 64'sd32768) >>> 16;
    endfunction

    static function sample_t clip(longint v);
      if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return sample_t'(v);
    endfunction

    // Keep only the register's own width, as the hardware does
    function void set_register(logic [CFG_INDEX_W-1:0] idx, cfg_word_t value);
      case (idx)
        CFG_DELAY:    delay_reg    = value[14:0];
        CFG_FEEDBACK: feedback_reg = value[15:0];
        CFG_MIX:      mix_reg      = value[16:0];
        CFG_LOWPASS:  coeff_reg    = value[16:0];
        CFG_BYPASS:   bypass_reg   = value[0];
        default: ;
      endcase
    endfunction

    function void note_input(sample_t xl, sample_t xr);
      logic [14:0]  eff_delay;
      logic [14:0]  read_index;
      longint       fb, mix, coeff, dl, dr;
      stereo_pair_t result;
      if (bypass_reg) begin
        result.left  = xl;
        result.right = xr;
        expected_pairs.push_back(result);
        return;
      end
      // Clamp settings: zero delay acts as one, gains saturate at their caps
      eff_delay  = (delay_reg == 15'd0) ? 15'd1 : delay_reg;
      fb         = (feedback_reg > FB_CAP) ? longint'(FB_CAP) : longint'(feedback_reg);
      mix        = (mix_reg > UNITY) ? longint'(UNITY) : longint'(mix_reg);
      coeff      = (coeff_reg > UNITY) ? longint'(UNITY) : longint'(coeff_reg);
      read_index = write_index - eff_delay;
      // Cross-read the opposite channel's line for the ping-pong
      dl = longint'(right_line[read_index]);
      dr = longint'(left_line[read_index]);
      left_lowpass  += scale_q16(dl - left_lowpass, coeff);
      right_lowpass += scale_q16(dr - right_lowpass, coeff);
      left_line[write_index]  = clip(longint'(xl) + scale_q16(left_lowpass, fb));
      right_line[write_index] = clip(longint'(xr) + scale_q16(right_lowpass, fb));
      result.left  = clip(longint'(xl) + scale_q16(dl - longint'(xl), mix));
      result.right = clip(longint'(xr) + scale_q16(dr - longint'(xr), mix));
      expected_pairs.push_back(result);
      write_index = write_index + 15'd1;
    endfunction

    function void check_output(sample_t yl, sample_t yr);
      stereo_pair_t exp_pair;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected output pair, expected none, actual %0d %0d",
                 $time, yl, yr);
        errors++;
        return;
      end
      exp_pair = expected_pairs.pop_front();
      if (yl !== exp_pair.left) begin
        $display("%0t: out_left mismatch, expected %0d, actual %0d",
                 $time, exp_pair.left, yl);
        errors++;
      end
      if (yr !== exp_pair.right) begin
        $display("%0t: out_right mismatch, expected %0d, actual %0d",
                 $time, exp_pair.right, yr);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  psd_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) audio_in ();
  psd_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) audio_out ();
  psd_cfg_if cfg ();

  pingpong_stereo_delay #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .audio_in  (audio_in),
    .audio_out (audio_out),
    .cfg       (cfg)
  );

  stereo_delay_scoreboard sb = new();

  int          burst_left   = 0;
  int          quiet_cycles = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  pattern_step  = '0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    audio_in.valid    = 1'b0;
    audio_in.in_left  = '0;
    audio_in.in_right = '0;
    audio_out.ready   = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;
  end

  // Stall the output side on a pattern, renewed each time the step counter wraps
  always @(posedge clk) begin
    if (pattern_step == 6'd0) begin
      if ($urandom_range(0, 3) == 0) begin
        ready_pattern <= 16'hFFFF;
      end else begin
        ready_pattern <= 16'($urandom()) | 16'h8001;
      end
    end
    audio_out.ready <= ready_pattern[pattern_step[3:0]];
    pattern_step    <= pattern_step + 6'd1;
  end

  // Check every accepted output pair
  always @(posedge clk) begin
    if (!rst && audio_out.valid && audio_out.ready) begin
      sb.check_output(audio_out.out_left, audio_out.out_right);
    end
  end

  // Count cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((audio_in.valid && audio_in.ready) || (audio_out.valid && audio_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Send one pair; open a random gap before each new burst
  task automatic send_pair(input sample_t xl, input sample_t xr);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        audio_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    audio_in.valid    <= 1'b1;
    audio_in.in_left  <= xl;
    audio_in.in_right <= xr;
    do @(posedge clk); while (!audio_in.ready);
    sb.note_input(xl, xr);
    burst_left--;
  endtask

  // Drop valid and wait until every expected pair has come out
  task automatic drain();
    audio_in.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input cfg_word_t value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.set_register(idx, value);
  endtask

  task automatic configure(input cfg_word_t delay_val, input cfg_word_t fb_val,
                           input cfg_word_t mix_val, input cfg_word_t coeff_val,
                           input cfg_word_t bypass_val);
    write_reg(CFG_DELAY, delay_val);
    write_reg(CFG_FEEDBACK, fb_val);
    write_reg(CFG_MIX, mix_val);
    write_reg(CFG_LOWPASS, coeff_val);
    write_reg(CFG_BYPASS, bypass_val);
    cfg.valid <= 1'b0;
  endtask

  // Half extremes, zero and small values, the rest full range
  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 24'($urandom_range(0, 8191) - 4096);
      3:       return '0;
      default: return 24'($urandom());
    endcase
  endfunction

  // Mix and lowpass share the same range: 0 .. unity, with values past unity
  function automatic cfg_word_t random_unity_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return UNITY;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'($urandom());
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int        sent;
    int        count;
    cfg_word_t delay_val;
    cfg_word_t fb_val;
    cfg_word_t bypass_val;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: dry output, no feedback
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair('0, '0);
    send_pair(-24'sd1, 24'sd1);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // Zero delay, gains above their caps: drive the write path into saturation
    configure(17'h10000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, '0);
    repeat (4) send_pair(SAMPLE_MAX, SAMPLE_MAX);
    repeat (3) send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair('0, '0);
    drain();

    // Bypass leaves the state untouched
    configure(17'h10000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'd1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(24'sd12345, -24'sd12345);
    send_pair(SAMPLE_MAX, '0);
    drain();

    // Longest delay, frozen lowpass, maximum feedback and fully wet
    configure(17'd32767, FB_CAP, UNITY, '0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(24'sd1, -24'sd1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    drain();

    // Random settings, each held for a random run of pairs
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       delay_val = '0;
        1:       delay_val = 17'd32767;
        2:       delay_val = {2'($urandom()), 15'($urandom_range(1, 32))};
        3:       delay_val = 17'($urandom());
        default: delay_val = 17'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       fb_val = '0;
        1:       fb_val = FB_CAP;
        2:       fb_val = 17'($urandom_range(64226, 65535));
        3:       fb_val = 17'($urandom());
        default: fb_val = 17'($urandom_range(0, 64225));
      endcase
      bypass_val = {16'($urandom()), ($urandom_range(0, 5) == 0)};
      configure(delay_val, fb_val, random_unity_gain(), random_unity_gain(), bypass_val);
      count = $urandom_range(20, 80);
      repeat (count) send_pair(random_sample(), random_sample());
      sent += count;
      drain();
    end

    // Let any stray output show up before the verdict
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
